// ===== rtl/core/lrle_pkg.sv =====
// Shared types, character codes and widths for the run-length pattern decoder.
`default_nettype none

package lrle_pkg;

	// Field and state widths
	localparam int unsigned DimW   = 13;
	localparam int unsigned PosW   = 25;
	localparam int unsigned StartW = 24;
	localparam int unsigned LenW   = 25;
	localparam int unsigned CharW  = 8;
	localparam int unsigned KindW  = 2;
	localparam int unsigned CountW = 25;

	// Largest board side; size registers above it are clamped to it
	localparam logic [DimW-1:0] MaxDimension = 13'd4096;

	// Pending count saturates here
	localparam logic [CountW-1:0] CountMax = '1;

	// Characters of the pattern body
	localparam logic [CharW-1:0] ChBang   = 8'h21; // '!'
	localparam logic [CharW-1:0] ChDollar = 8'h24; // '$'
	localparam logic [CharW-1:0] ChLive   = 8'h6f; // 'o'
	localparam logic [CharW-1:0] ChDead   = 8'h62; // 'b'
	localparam logic [CharW-1:0] ChZero   = 8'h30; // '0'
	localparam logic [CharW-1:0] ChNine   = 8'h39; // '9'
	localparam logic [CharW-1:0] ChSpace  = 8'h20; // ' '
	localparam logic [CharW-1:0] ChTab    = 8'h09; // tab, first of the control blanks
	localparam logic [CharW-1:0] ChCr     = 8'h0d; // carriage return, last of them

	// Register indexes on the configuration port
	localparam logic RegColumns = 1'b0;
	localparam logic RegRows    = 1'b1;

	// Result kinds
	localparam logic [KindW-1:0] KindRun  = 2'd0;
	localparam logic [KindW-1:0] KindPass = 2'd1;
	localparam logic [KindW-1:0] KindFail = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECODE,
		ST_DIV,
		ST_EMIT
	} seq_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/lrle_rem.sv =====
// Bit-serial remainder unit: dividend modulo divisor, one dividend bit per cycle.
`default_nettype none

module lrle_rem (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [lrle_pkg::PosW-1:0]    dividend,
	input  wire logic [lrle_pkg::DimW-1:0]    divisor,
	output logic                              done,
	output logic      [lrle_pkg::DimW-1:0]    remainder
);

	localparam int unsigned CntW = $clog2(lrle_pkg::PosW);
	localparam logic [CntW-1:0] LastStep = CntW'(lrle_pkg::PosW - 1);

	logic                        busy_q;
	logic                        done_q;
	logic [CntW-1:0]             cnt_q;
	logic [lrle_pkg::PosW-1:0]   shift_q;
	logic [lrle_pkg::DimW-1:0]   div_q;
	logic [lrle_pkg::DimW-1:0]   rem_q;
	logic [lrle_pkg::DimW:0]     trial;
	logic [lrle_pkg::DimW-1:0]   rem_next;

	// Bring down the next dividend bit; subtract when it fits
	always_comb begin
		trial = {rem_q, shift_q[lrle_pkg::PosW-1]};
		if (trial >= {1'b0, div_q}) begin
			rem_next = lrle_pkg::DimW'(trial - {1'b0, div_q});
		end else begin
			rem_next = trial[lrle_pkg::DimW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LastStep) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= dividend;
			div_q   <= divisor;
			rem_q   <= '0;
		end else if (busy_q) begin
			shift_q <= {shift_q[lrle_pkg::PosW-2:0], 1'b0};
			rem_q   <= rem_next;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

// ===== rtl/core/life_rle_pattern_decoder.sv =====
// Top level of the run-length pattern decoder: sequencer, parse state and result register.
`default_nettype none

// Usage:
//   Software writes board_columns (index 0) and board_rows (index 1) on the
//   cfg port before the pattern body streams in; both reset to 1. Values of
//   0 act as 1, values above the maximum dimension act as the maximum.
//   The slave stream carries one character per word in s_axis_tdata; set
//   s_axis_tuser on the first word of a board to clear position, pending
//   count and the finished flag before that character is parsed.
//   The master stream gives at most one result per character: tuser is the
//   kind (live run write, pass, fail), tdata the run start cell and length.
//   A character that gives no result passes through the decode state and
//   back to idle before the next one is taken. A '$' before the board end
//   runs the serial remainder unit, one dividend bit a cycle over the
//   25-bit cell position. A character that gives a result also passes
//   through the emit state, which moves it into the output register.
//   The output register parts the two sides: a new word is taken while a
//   result still waits; only a second result stalls in the emit state until
//   the receiver takes the first one.
//   Reset clears the parse state, empties the output and sets both sizes
//   to 1.
module life_rle_pattern_decoder (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration
	input  wire logic                          cfg_we,
	input  wire logic                          cfg_index,
	input  wire logic [lrle_pkg::DimW-1:0]     cfg_data,
	// character stream
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire logic [7:0]                    s_axis_tdata,  // [7:0] text_char
	input  wire logic                          s_axis_tuser,  // [0] start_of_board
	// result stream
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	output logic [55:0]                        m_axis_tdata,  // [23:0] run_start, [48:24] run_length
	output logic [lrle_pkg::KindW-1:0]         m_axis_tuser   // [1:0] result_kind
);

	localparam int unsigned PosW = lrle_pkg::PosW;
	localparam int unsigned DimW = lrle_pkg::DimW;

	// Configuration and board size
	logic [DimW-1:0]   cols_q, rows_q;
	logic [DimW-1:0]   cols_c, rows_c;
	logic [2*DimW-1:0] prod;
	logic [PosW-1:0]   cells_s1;

	// Parse state
	lrle_pkg::seq_state_t state_q, state_d;
	logic [PosW-1:0]   pos_q, pos_d;
	logic [lrle_pkg::CountW-1:0] pend_q, pend_d;
	logic              digits_q, digits_d;
	logic              fin_q, fin_d;
	logic [lrle_pkg::CharW-1:0] char_q;
	logic              sob_q;

	// Values after a start-of-board clear
	logic [PosW-1:0]   pos_e;
	logic [lrle_pkg::CountW-1:0] pend_e;
	logic              digits_e, fin_e;

	logic              is_blank, is_digit;
	logic [lrle_pkg::CountW+3:0] pend_x10;
	logic [lrle_pkg::CountW-1:0] count_e;
	logic [PosW:0]     run_end;

	// Staged result and output register
	logic              res_we;
	logic [lrle_pkg::KindW-1:0]  res_kind_q, res_kind_d;
	logic [lrle_pkg::StartW-1:0] res_start_q, res_start_d;
	logic [lrle_pkg::LenW-1:0]   res_len_q, res_len_d;
	logic              out_load;
	logic              out_valid_q;
	logic [lrle_pkg::KindW-1:0]  out_kind_q;
	logic [lrle_pkg::StartW-1:0] out_start_q;
	logic [lrle_pkg::LenW-1:0]   out_len_q;

	// Remainder unit
	logic              div_start;
	logic              div_done;
	logic [DimW-1:0]   div_rem;

	// Clamp the size registers into range
	always_comb begin
		if (cols_q == '0) begin
			cols_c = DimW'(1);
		end else if (cols_q > lrle_pkg::MaxDimension) begin
			cols_c = lrle_pkg::MaxDimension;
		end else begin
			cols_c = cols_q;
		end
		if (rows_q == '0) begin
			rows_c = DimW'(1);
		end else if (rows_q > lrle_pkg::MaxDimension) begin
			rows_c = lrle_pkg::MaxDimension;
		end else begin
			rows_c = rows_q;
		end
	end

	// Board size never exceeds 2^24, so the low 25 bits of the product hold it
	assign prod = (2*DimW)'(cols_c) * (2*DimW)'(rows_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= DimW'(1);
			rows_q <= DimW'(1);
		end else if (cfg_we) begin
			if (cfg_index == lrle_pkg::RegColumns) begin
				cols_q <= cfg_data;
			end
			if (cfg_index == lrle_pkg::RegRows) begin
				rows_q <= cfg_data;
			end
		end
	end

	// Refresh every cycle; the block relies on the user to change the size only while idle
	always_ff @(posedge clk) begin
		cells_s1 <= prod[PosW-1:0];
	end

	// Apply start-of-board before the character is parsed
	assign pos_e    = sob_q ? '0 : pos_q;
	assign pend_e   = sob_q ? '0 : pend_q;
	assign digits_e = sob_q ? 1'b0 : digits_q;
	assign fin_e    = sob_q ? 1'b0 : fin_q;

	assign is_blank = (char_q == lrle_pkg::ChSpace) ||
	                  ((char_q >= lrle_pkg::ChTab) && (char_q <= lrle_pkg::ChCr));
	assign is_digit = (char_q >= lrle_pkg::ChZero) && (char_q <= lrle_pkg::ChNine);

	// Decimal accumulate: count * 8 + count * 2 + digit
	assign pend_x10 = {pend_e, 3'b000} + {2'b00, pend_e, 1'b0}
	                + (lrle_pkg::CountW+4)'(char_q - lrle_pkg::ChZero);

	assign count_e = digits_e ? pend_e : lrle_pkg::CountW'(1);
	assign run_end = {1'b0, pos_e} + {1'b0, count_e};

	always_comb begin
		state_d       = state_q;
		pos_d         = pos_q;
		pend_d        = pend_q;
		digits_d      = digits_q;
		fin_d         = fin_q;
		res_we        = 1'b0;
		res_kind_d    = lrle_pkg::KindRun;
		res_start_d   = '0;
		res_len_d     = '0;
		div_start     = 1'b0;
		out_load      = 1'b0;
		s_axis_tready = 1'b0;
		unique case (state_q)
			lrle_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = lrle_pkg::ST_DECODE;
				end
			end
			lrle_pkg::ST_DECODE: begin
				pos_d    = pos_e;
				pend_d   = pend_e;
				digits_d = digits_e;
				fin_d    = fin_e;
				state_d  = lrle_pkg::ST_IDLE;
				priority if (fin_e || is_blank) begin
					// drop the character
				end else if (is_digit) begin
					pend_d   = (pend_x10 > (lrle_pkg::CountW+4)'(lrle_pkg::CountMax)) ?
					           lrle_pkg::CountMax : pend_x10[lrle_pkg::CountW-1:0];
					digits_d = 1'b1;
				end else begin
					pend_d   = '0;
					digits_d = 1'b0;
					priority if (pos_e >= cells_s1) begin
						// board full: only '!' passes
						fin_d      = 1'b1;
						res_we     = 1'b1;
						res_kind_d = (char_q == lrle_pkg::ChBang) ?
						             lrle_pkg::KindPass : lrle_pkg::KindFail;
						state_d    = lrle_pkg::ST_EMIT;
					end else if (char_q == lrle_pkg::ChBang) begin
						// early end passes with exactly one cell left
						fin_d      = 1'b1;
						res_we     = 1'b1;
						res_kind_d = ((pos_e + PosW'(1)) == cells_s1) ?
						             lrle_pkg::KindPass : lrle_pkg::KindFail;
						state_d    = lrle_pkg::ST_EMIT;
					end else if (char_q == lrle_pkg::ChDollar) begin
						div_start = 1'b1;
						state_d   = lrle_pkg::ST_DIV;
					end else if ((char_q == lrle_pkg::ChLive) ||
					             (char_q == lrle_pkg::ChDead)) begin
						if (run_end > {1'b0, cells_s1}) begin
							fin_d      = 1'b1;
							res_we     = 1'b1;
							res_kind_d = lrle_pkg::KindFail;
							state_d    = lrle_pkg::ST_EMIT;
						end else begin
							pos_d = run_end[PosW-1:0];
							if ((char_q == lrle_pkg::ChLive) && (count_e != '0)) begin
								// run stays on the board, so no clipping is left to do
								res_we      = 1'b1;
								res_kind_d  = lrle_pkg::KindRun;
								res_start_d = pos_e[lrle_pkg::StartW-1:0];
								res_len_d   = count_e;
								state_d     = lrle_pkg::ST_EMIT;
							end
						end
					end else begin
						// other characters only drop the count
					end
				end
			end
			lrle_pkg::ST_DIV: begin
				if (div_done) begin
					if (div_rem != '0) begin
						pos_d = pos_q + PosW'(cols_c) - PosW'(div_rem);
					end
					state_d = lrle_pkg::ST_IDLE;
				end
			end
			lrle_pkg::ST_EMIT: begin
				if (!out_valid_q || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = lrle_pkg::ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lrle_pkg::ST_IDLE;
			pos_q       <= '0;
			pend_q      <= '0;
			digits_q    <= 1'b0;
			fin_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			pos_q    <= pos_d;
			pend_q   <= pend_d;
			digits_q <= digits_d;
			fin_q    <= fin_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold the accepted word and staged result; advance payload into the output
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			char_q <= s_axis_tdata;
			sob_q  <= s_axis_tuser;
		end
		if (res_we) begin
			res_kind_q  <= res_kind_d;
			res_start_q <= res_start_d;
			res_len_q   <= res_len_d;
		end
		if (out_load) begin
			out_kind_q  <= res_kind_q;
			out_start_q <= res_start_q;
			out_len_q   <= res_len_q;
		end
	end

	lrle_rem u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (pos_e),
		.divisor   (cols_c),
		.done      (div_done),
		.remainder (div_rem)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tdata  = {7'b0, out_len_q, out_start_q};

endmodule

`default_nettype wire

// ===== test/lrle_checker.sv =====
// Checker for the run-length pattern decoder: tracks parse state and compares result words.
`default_nettype none

module lrle_checker
	import lrle_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire logic [DimW-1:0]   cfg_data,
	input  wire logic              s_axis_tvalid,
	input  wire logic              s_axis_tready,
	input  wire logic [7:0]        s_axis_tdata,  // [7:0] text_char
	input  wire logic              s_axis_tuser,  // [0] start_of_board
	input  wire logic              m_axis_tvalid,
	input  wire logic              m_axis_tready,
	input  wire logic [55:0]       m_axis_tdata,  // [23:0] run_start, [48:24] run_length
	input  wire logic [KindW-1:0]  m_axis_tuser,  // [1:0] result_kind
	output int                     fail_count,
	output int                     runs_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [KindW-1:0]  kind;
		logic [StartW-1:0] start;
		logic [LenW-1:0]   len;
	} run_word_t;

	run_word_t       expected_runs[$];
	logic [DimW-1:0] cols_reg;
	logic [DimW-1:0] rows_reg;
	longint unsigned cursor;
	longint unsigned digit_count;
	logic            digit_flag;
	logic            board_closed;
	int              mismatches = 0;
	int              owed = 0;

	assign fail_count = mismatches;
	assign runs_owed  = owed;

	function automatic longint unsigned side(logic [DimW-1:0] raw);
		if (raw == 0)
			return 1;
		if (raw > MaxDimension)
			return MaxDimension;
		return raw;
	endfunction

	function automatic void close_board(logic pass);
		run_word_t w;
		w.kind = pass ? KindPass : KindFail;
		w.start = '0;
		w.len = '0;
		expected_runs.push_back(w);
		board_closed = 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		longint unsigned cols;
		longint unsigned cells;
		longint unsigned run;
		longint unsigned room;
		logic [7:0]      ch;
		run_word_t       got;
		run_word_t       want;
		if (!arst_n) begin
			cols_reg = DimW'(1);
			rows_reg = DimW'(1);
			cursor = 0;
			digit_count = 0;
			digit_flag = 1'b0;
			board_closed = 1'b0;
			expected_runs.delete();
			owed <= 0;
		end else begin
			// results leave only after their character was taken, so compare first
			if (m_axis_tvalid && m_axis_tready) begin
				got.kind = m_axis_tuser;
				got.start = m_axis_tdata[StartW-1:0];
				got.len = m_axis_tdata[StartW +: LenW];
				if (expected_runs.size() == 0) begin
					if (mismatches < 10)
						$display("%t: unexpected result word kind %0d start %0d len %0d",
							$realtime, got.kind, got.start, got.len);
					mismatches++;
				end else begin
					want = expected_runs.pop_front();
					if (got.kind !== want.kind || got.start !== want.start ||
							got.len !== want.len) begin
						if (mismatches < 10) begin
							$display("%t: result word mismatch: expected kind %0d start %0d len %0d",
								$realtime, want.kind, want.start, want.len);
							$display("%t: result word mismatch: got kind %0d start %0d len %0d",
								$realtime, got.kind, got.start, got.len);
						end
						mismatches++;
					end
				end
			end
			if (cfg_we) begin
				if (cfg_index == RegColumns)
					cols_reg = cfg_data;
				else
					rows_reg = cfg_data;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				cols = side(cols_reg);
				cells = cols * side(rows_reg);
				ch = s_axis_tdata;
				if (s_axis_tuser) begin
					cursor = 0;
					digit_count = 0;
					digit_flag = 1'b0;
					board_closed = 1'b0;
				end
				if (board_closed || ch == ChSpace || (ch >= ChTab && ch <= ChCr)) begin
					// skipped
				end else if (ch >= ChZero && ch <= ChNine) begin
					digit_count = digit_count * 10 + (ch - ChZero);
					if (digit_count > CountMax)
						digit_count = CountMax;
					digit_flag = 1'b1;
				end else begin
					run = digit_flag ? digit_count : 1;
					digit_count = 0;
					digit_flag = 1'b0;
					if (cursor >= cells)
						close_board(ch == ChBang);
					else if (ch == ChBang)
						close_board(cursor + 1 == cells);
					else if (ch == ChDollar) begin
						if (cursor % cols != 0)
							cursor += cols - cursor % cols;
					end else if (ch == ChLive || ch == ChDead) begin
						if (cursor + run > cells)
							close_board(1'b0);
						else begin
							if (ch == ChLive && run != 0) begin
								room = cells - cursor;
								want.kind = KindRun;
								want.start = cursor[StartW-1:0];
								want.len = (run < room) ? run[LenW-1:0] : room[LenW-1:0];
								expected_runs.push_back(want);
							end
							cursor += run;
						end
					end
				end
			end
			owed <= expected_runs.size();
		end
	end

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Testbench top for the run-length pattern decoder: stimulus, receiver stalls and verdict.
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lrle_pkg::*;

	localparam int unsigned WordTarget  = 1950;
	localparam int unsigned StallLimit  = 4000;
	// longest job is a '$' through the serial remainder
	localparam int unsigned DrainCycles = 40;
	// any character that is neither tag, digit nor blank
	localparam logic [7:0]  ChStray     = 8'h78;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic              cfg_index = RegColumns;
	logic [DimW-1:0]   cfg_data = '0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [7:0]        s_axis_tdata = '0;  // [7:0] text_char
	logic              s_axis_tuser = 1'b0; // [0] start_of_board
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [55:0]       m_axis_tdata;        // [23:0] run_start, [48:24] run_length
	logic [KindW-1:0]  m_axis_tuser;        // [1:0] result_kind

	int                fail_count;
	int                runs_owed;
	logic              no_gaps = 1'b0;
	logic              board_head = 1'b0;
	int unsigned       words_sent = 0;
	int unsigned       quiet_cycles = 0;

	life_rle_pattern_decoder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	lrle_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.fail_count    (fail_count),
		.runs_owed     (runs_owed)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Receiver: stall about a third of the cycles, never while no_gaps holds.
	always @(posedge clk) begin
		m_axis_tready <= no_gaps || ($urandom_range(99) >= 32);
	end

	// Watchdog: give up once no word has moved on either side for too long.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= StallLimit) begin
			$display("DONE: errors detected");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	// Offer one word and hold it until the block takes it; idle first at random.
	task automatic send_word(input logic [7:0] ch, input logic head);
		while (!no_gaps && $urandom_range(99) < 32) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= ch;
		s_axis_tuser <= head;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	function automatic logic [7:0] pick_blank();
		int unsigned pick;
		pick = $urandom_range(5);
		return (pick == 0) ? ChSpace : ChTab + 8'(pick - 1);
	endfunction

	// Send one pattern character, now and then behind a blank; the board-start
	// flag rides on whichever word goes first.
	task automatic put_char(input logic [7:0] ch);
		if ($urandom_range(99) < 4)
			send_word(pick_blank(), board_head);
		send_word(ch, board_head);
		board_head = 1'b0;
		words_sent++;
	endtask

	// Decimal run count, sometimes with a leading zero.
	task automatic put_count(input longint unsigned n);
		string digits;
		if ($urandom_range(9) == 0)
			put_char(ChZero);
		digits = $sformatf("%0d", n);
		foreach (digits[i])
			put_char(digits[i]);
	endtask

	task automatic write_reg(input logic idx, input logic [DimW-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Drop valid, wait for every owed result, then let any silent job finish.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (runs_owed != 0);
		repeat (DrainCycles)
			@(posedge clk);
	endtask

	// Raw size register value: mostly small boards, with the extremes and
	// out-of-range values mixed in.
	function automatic logic [DimW-1:0] pick_side();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 8)
			return '0;
		if (roll < 14)
			return '1;
		if (roll < 20)
			return MaxDimension;
		if (roll < 26)
			return DimW'($urandom);
		if (roll < 34)
			return DimW'(1);
		return DimW'($urandom_range(2, 12));
	endfunction

	function automatic longint unsigned span_of(logic [DimW-1:0] raw);
		return (raw == 0) ? 1 : ((raw > MaxDimension) ? MaxDimension : raw);
	endfunction

	initial begin
		logic [7:0]      opening[$];
		logic [DimW-1:0] raw_cols;
		logic [DimW-1:0] raw_rows;
		longint unsigned cols;
		longint unsigned cells;
		longint unsigned pos;
		longint unsigned col;
		longint unsigned rem;
		longint unsigned len;
		longint unsigned reach;
		int unsigned     roll;
		int unsigned     tokens;
		int unsigned     boards;
		int unsigned     phase;
		string           digits;

		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, 3 x 2 board: run, blank, '$' mid-row and at row start,
		// zero counts on both tags, count dropped by a stray character,
		// '!' with one cell left, and a character after the board closed.
		write_reg(RegColumns, 3);
		write_reg(RegRows, 2);
		opening = '{ChZero + 8'd2, ChLive, ChSpace, ChDollar, ChDollar, ChZero, ChLive,
			ChZero, ChDead, ChZero + 8'd7, ChStray, ChLive, ChDead, ChBang, ChLive};
		foreach (opening[i])
			send_word(opening[i], i == 0);
		words_sent += opening.size();
		settle();

		// Directed, largest board with clamped columns: one run over every cell,
		// then '!' exactly at the board end.
		write_reg(RegColumns, '1);
		write_reg(RegRows, MaxDimension);
		digits = $sformatf("%0d", 64'd1 << 24);
		foreach (digits[i])
			send_word(digits[i], i == 0);
		send_word(ChLive, 1'b0);
		send_word(ChBang, 1'b0);
		words_sent += digits.len() + 2;
		settle();

		phase = 0;
		while (words_sent < WordTarget) begin
			raw_cols = pick_side();
			raw_rows = pick_side();
			write_reg(RegColumns, raw_cols);
			write_reg(RegRows, raw_rows);
			cols = span_of(raw_cols);
			cells = cols * span_of(raw_rows);
			// every fifth phase runs with no idling on either side
			no_gaps <= (phase % 5 == 2);
			boards = $urandom_range(3, 8);
			while (boards != 0 && words_sent < WordTarget) begin
				board_head = 1'b1;
				if ($urandom_range(99) < 75) begin
					// Well-formed board: runs and row ends that track the position.
					pos = 0;
					tokens = 0;
					while (pos < cells && tokens < 40 && words_sent < WordTarget) begin
						rem = cells - pos;
						col = pos % cols;
						roll = $urandom_range(99);
						if (rem == 1 && roll < 30)
							break;
						if (roll < 12 && col != 0) begin
							// a count before '$' is dropped
							if ($urandom_range(3) == 0)
								put_count($urandom_range(1, 30));
							put_char(ChDollar);
							pos += cols - col;
						end else if (roll < 16) begin
							put_count(0);
							put_char($urandom_range(1) ? ChLive : ChDead);
						end else begin
							reach = (cols - col < rem) ? cols - col : rem;
							len = (roll < 60) ? $urandom_range(1, reach) : $urandom_range(1, rem);
							if (len != 1 || $urandom_range(1))
								put_count(len);
							put_char($urandom_range(2) != 0 ? ChLive : ChDead);
							pos += len;
						end
						tokens++;
					end
					roll = $urandom_range(99);
					if (roll < 10) begin
						// overrun past the board end
						put_count(cells - pos + $urandom_range(1, 3));
						put_char($urandom_range(1) ? ChLive : ChDead);
					end else if (roll < 15) begin
						// count that saturates
						put_count(999999999);
						put_char(ChLive);
					end else if (roll < 20)
						put_char(ChLive);
					else
						put_char(ChBang);
				end else begin
					// Noise: random mix of tags, digits, blanks and any byte,
					// with the board-start flag now and then mid-stream.
					repeat ($urandom_range(4, 24)) begin
						roll = $urandom_range(99);
						if ($urandom_range(15) == 0)
							board_head = 1'b1;
						if (roll < 30)
							put_char(ChZero + 8'($urandom_range(9)));
						else if (roll < 42)
							put_char(ChLive);
						else if (roll < 54)
							put_char(ChDead);
						else if (roll < 64)
							put_char(ChDollar);
						else if (roll < 70)
							put_char(ChBang);
						else if (roll < 76)
							put_char(pick_blank());
						else
							put_char(8'($urandom_range(255)));
					end
				end
				boards--;
			end
			settle();
			phase++;
		end

		if (fail_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire
